>>> hw/rtl/button_debounce_event_detector_macros.svh
//------------------------------------------------------------------------------
// Assertion macros for the button debounce event detector
// Wrap concurrent assertions so that they can be compiled out with ASSERT_OFF.
//------------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_EVENT_DETECTOR_MACROS_SVH
`define BUTTON_DEBOUNCE_EVENT_DETECTOR_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/bded_pkg.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Button debounce event detector package
// Shared types and constants: commands, register indexes, config, flags and result.
//------------------------------------------------------------------------------
package bded_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int SETTLE_BITS    = 16;
   localparam int WINDOW_BITS    = 16;
   localparam int HOLD_BITS      = 32;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESS_LEVEL   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SETTLE_TICKS  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECENT_WINDOW = 2'd2;

   localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = 16'd20;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd300;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_PRESS   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_LONG    = 2'd3
   } cmd_type;

   typedef struct packed {
      logic                   press_level;
      logic [SETTLE_BITS-1:0] settle_ticks;
      logic [WINDOW_BITS-1:0] recent_window;
   } cfg_type;

   typedef struct packed {
      logic pressed;
      logic released;
      logic prev_level;
      logic waiting;
      logic edge_pending;
   } flags_type;

   typedef struct packed {
      logic settling;
      logic answer;
      logic level_is_pressed;
   } result_type;

endpackage

>>> hw/rtl/bded_step.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Debounce step logic
// Next-state and result for one tick: edge handling, settle wait, queries.
//------------------------------------------------------------------------------
module bded_step #(
   parameter int TIME_BITS = 32
) (
   input  bded_pkg::cfg_type                  cfg_i,
   input  bded_pkg::cmd_type                  cmd_i,
   input  logic                               pin_i,
   input  logic [bded_pkg::HOLD_BITS-1:0]     hold_i,
   input  logic [TIME_BITS-1:0]               now_i,
   input  logic [TIME_BITS-1:0]               press_stamp_i,
   input  logic [TIME_BITS-1:0]               release_stamp_i,
   input  logic [TIME_BITS-1:0]               edge_stamp_i,
   input  logic [bded_pkg::SETTLE_BITS-1:0]   wait_count_i,
   input  bded_pkg::flags_type                flags_i,
   output logic [TIME_BITS-1:0]               press_stamp_o,
   output logic [TIME_BITS-1:0]               release_stamp_o,
   output logic [TIME_BITS-1:0]               edge_stamp_o,
   output logic [bded_pkg::SETTLE_BITS-1:0]   wait_count_o,
   output bded_pkg::flags_type                flags_o,
   output bded_pkg::result_type               result_o
);
   import bded_pkg::*;

   localparam int CMP_BITS = (TIME_BITS > HOLD_BITS) ? TIME_BITS : HOLD_BITS;

   logic [TIME_BITS-1:0] d_press;
   logic [TIME_BITS-1:0] d_release;
   logic [TIME_BITS-1:0] d_edge;
   logic [TIME_BITS-1:0] settle_w;
   logic [TIME_BITS-1:0] window_w;

   // elapsed time since each stored stamp, modulo the time base
   assign d_press   = now_i - press_stamp_i;
   assign d_release = now_i - release_stamp_i;
   assign d_edge    = now_i - edge_stamp_i;
   assign settle_w  = TIME_BITS'(cfg_i.settle_ticks);
   assign window_w  = TIME_BITS'(cfg_i.recent_window);

   always_comb begin
      logic                   chg;
      logic                   start_req;
      logic                   ans;
      logic [TIME_BITS-1:0]   dps;
      logic [TIME_BITS-1:0]   drs;

      chg             = (pin_i != flags_i.prev_level);
      start_req       = 1'b0;
      ans             = 1'b0;
      dps             = d_press;
      drs             = d_release;
      press_stamp_o   = press_stamp_i;
      release_stamp_o = release_stamp_i;
      edge_stamp_o    = edge_stamp_i;
      wait_count_o    = wait_count_i;
      flags_o         = flags_i;
      flags_o.prev_level = pin_i;

      if (flags_i.waiting) begin
         if (chg) begin
            flags_o.edge_pending = 1'b1;
         end
         if (wait_count_o != '0) begin
            wait_count_o = wait_count_o - 1'b1;
         end
         if (wait_count_o == '0) begin
            // wait over: sample the pin, stamp with the start of the wait
            if (pin_i == cfg_i.press_level) begin
               flags_o.pressed = 1'b1;
               press_stamp_o   = edge_stamp_i;
               dps             = d_edge;
            end else begin
               flags_o.released = 1'b1;
               release_stamp_o  = edge_stamp_i;
               drs              = d_edge;
            end
            flags_o.waiting = 1'b0;
            if (flags_o.edge_pending) begin
               flags_o.edge_pending = 1'b0;
               start_req            = 1'b1;
            end
         end
      end else if (chg) begin
         start_req = 1'b1;
      end

      // new wait unless locked out by a recent press or release
      if (start_req && (dps >= settle_w) && (drs >= settle_w)) begin
         edge_stamp_o    = now_i;
         flags_o.waiting = 1'b1;
         wait_count_o    = cfg_i.settle_ticks;
         if (cfg_i.settle_ticks == '0) begin
            if (pin_i == cfg_i.press_level) begin
               flags_o.pressed = 1'b1;
               press_stamp_o   = now_i;
               dps             = '0;
            end else begin
               flags_o.released = 1'b1;
               release_stamp_o  = now_i;
               drs              = '0;
            end
            flags_o.waiting = 1'b0;
         end
      end

      unique case (cmd_i)
         CMD_PRESS: begin
            ans             = flags_o.pressed && (dps < window_w);
            flags_o.pressed = 1'b0;
         end
         CMD_RELEASE: begin
            ans              = flags_o.released && (drs < window_w);
            flags_o.released = 1'b0;
         end
         CMD_LONG: begin
            if (flags_o.pressed && (CMP_BITS'(dps) > CMP_BITS'(hold_i))
                && (press_stamp_o > release_stamp_o)) begin
               flags_o.pressed = 1'b0;
               ans             = 1'b1;
            end
         end
         CMD_TICK: begin
            ans = 1'b0;
         end
      endcase

      result_o.level_is_pressed = (pin_i == cfg_i.press_level);
      result_o.answer           = ans;
      result_o.settling         = flags_o.waiting;
   end

endmodule

>>> hw/rtl/button_debounce_event_detector.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Button debounce event detector
// Debounces a sampled button pin and answers press, release and long-press
// queries against a wrapping tick counter.
//------------------------------------------------------------------------------
// Each request transaction is one tick of the time base and produces exactly
// one response transaction. The block takes one transaction per clock while
// the response side is ready: a request lands in an input register, then the
// step logic updates the debounce state and loads the result register, from
// which the response is offered. The sustained rate is set by the state
// update loop (stamps, flags, wait counter). Backpressure on the response
// side holds the result register and, through it, the input register.
// Configuration writes take effect on the next tick; write them only while
// no transaction is in flight.
module button_debounce_event_detector #(
   parameter int TIME_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: tdata = pin_level[0], hold_ticks[32:1], zero pad
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [39:0]                           req_tdata,
   // request: tuser = command[1:0]
   input  logic [1:0]                            req_tuser,
   // response: tdata = level_is_pressed[0], answer[1], settling[2], zero pad
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,
   // register write port
   input  logic                                  csr_we,
   input  logic [bded_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bded_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import bded_pkg::*;

`include "button_debounce_event_detector_macros.svh"

   // configuration
   cfg_type                 cfg_ff;

   // input stage
   logic                    in_v_ff;
   cmd_type                 cmd_ff;
   logic                    pin_ff;
   logic [HOLD_BITS-1:0]    hold_ff;

   // debounce state
   logic [TIME_BITS-1:0]    tick_ff;
   logic [TIME_BITS-1:0]    press_stamp_ff,   press_stamp_in;
   logic [TIME_BITS-1:0]    release_stamp_ff, release_stamp_in;
   logic [TIME_BITS-1:0]    edge_stamp_ff,    edge_stamp_in;
   logic [SETTLE_BITS-1:0]  wait_count_ff,    wait_count_in;
   flags_type               flags_ff,         flags_in;

   // result stage
   logic                    out_v_ff;
   result_type              res_ff,           res_in;

   logic                    advance;
   logic                    step;

   // result register moves when empty or taken; input register follows it
   assign advance    = !out_v_ff || rsp_tready;
   assign step       = in_v_ff && advance;
   assign req_tready = !in_v_ff || advance;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {5'd0, res_ff.settling, res_ff.answer, res_ff.level_is_pressed};

   bded_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .cfg_i           (cfg_ff),
      .cmd_i           (cmd_ff),
      .pin_i           (pin_ff),
      .hold_i          (hold_ff),
      .now_i           (tick_ff),
      .press_stamp_i   (press_stamp_ff),
      .release_stamp_i (release_stamp_ff),
      .edge_stamp_i    (edge_stamp_ff),
      .wait_count_i    (wait_count_ff),
      .flags_i         (flags_ff),
      .press_stamp_o   (press_stamp_in),
      .release_stamp_o (release_stamp_in),
      .edge_stamp_o    (edge_stamp_in),
      .wait_count_o    (wait_count_in),
      .flags_o         (flags_in),
      .result_o        (res_in)
   );

   // configuration registers; an unused index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_level   <= 1'b0;
         cfg_ff.settle_ticks  <= SETTLE_RESET;
         cfg_ff.recent_window <= WINDOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PRESS_LEVEL:   cfg_ff.press_level   <= csr_wdata[0];
            CSR_SETTLE_TICKS:  cfg_ff.settle_ticks  <= csr_wdata[SETTLE_BITS-1:0];
            CSR_RECENT_WINDOW: cfg_ff.recent_window <= csr_wdata[WINDOW_BITS-1:0];
            default: ;
         endcase
      end
   end

   // input stage: capture a request transaction whenever there is room
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_tready) begin
         in_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cmd_ff  <= cmd_type'(req_tuser);
         pin_ff  <= req_tdata[0];
         hold_ff <= req_tdata[HOLD_BITS:1];
      end
   end

   // debounce state: advance once per processed tick
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff          <= '0;
         press_stamp_ff   <= '0;
         release_stamp_ff <= '0;
         edge_stamp_ff    <= '0;
         wait_count_ff    <= '0;
         flags_ff         <= '0;
      end else if (step) begin
         tick_ff          <= tick_ff + 1'b1;
         press_stamp_ff   <= press_stamp_in;
         release_stamp_ff <= release_stamp_in;
         edge_stamp_ff    <= edge_stamp_in;
         wait_count_ff    <= wait_count_in;
         flags_ff         <= flags_in;
      end
   end

   // result stage: hold while the response side stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (advance) begin
         out_v_ff <= in_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         res_ff <= res_in;
      end
   end

   // tick counter moves by exactly one per processed transaction
   `ASSERT_NXT(a_tick_step, clock, reset, step,
      tick_ff == TIME_BITS'($past(tick_ff) + 1'b1))
   `ASSERT_NXT(a_tick_hold, clock, reset, !step, $stable(tick_ff))
   // an idle debouncer has no count left
   `ASSERT_IMP(a_idle_count, clock, reset, !flags_ff.waiting, wait_count_ff == '0)
   // a pending edge only exists during a settle wait
   `ASSERT_IMP(a_pending_wait, clock, reset, flags_ff.edge_pending, flags_ff.waiting)

endmodule
